>>> rtl/rspw_pkg.sv
package rspw_pkg;

  // Fixed field widths and number format.
  localparam int unsigned CoordW       = 32;
  localparam int unsigned FracBits     = 24;
  localparam int unsigned CordicSteps  = 24;
  localparam int unsigned StepW        = 5;
  localparam int unsigned IterLimitDef = 1024;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  // Datapath widths.
  localparam int unsigned EW    = CoordW + 1;
  localparam int unsigned MulW  = EW;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 128;
  localparam int unsigned HalfW = 31;
  localparam int unsigned CordW = CoordW + 4;
  localparam int unsigned AngW  = 26;

  // Half a turn in Q.24 half-turn units.
  localparam logic signed [AngW-1:0] HalfTurn = AngW'(1) <<< FracBits;

  typedef struct packed {
    logic [10:0]        max_iterations;
    logic [9:0]         sweet_iteration;
    logic               alt_shapes;
    logic signed [31:0] cutoff;
    logic signed [31:0] radius;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [63:0]        rotation_step;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     used_latched_point;
  } out_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxIter  = 3'd0,
    RegSweet    = 3'd1,
    RegAlt      = 3'd2,
    RegCutoff   = 3'd3,
    RegRadius   = 3'd4,
    RegOffX     = 3'd5,
    RegOffY     = 3'd6,
    RegRotStep  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    MulNone, MulAx2, MulAy2, MulCo2, MulRr, MulDd, MulEe,
    MulL00, MulL01, MulL10, MulL11, MulRxC, MulRyS, MulRxS, MulRyC
  } mul_sel_e;

  typedef enum logic [2:0] {
    AccHold, AccLoad, AccAdd, AccSub, AccAdd31, AccAdd62
  } acc_op_e;

  typedef enum logic [2:0] {
    HitNone, HitSquare, HitCircle, HitLemni, HitAngle, HitAngleZero
  } hit_sel_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             load;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    logic             cut_eval;
    logic             rr_load;
    logic             dd_load;
    logic             e2_load;
    hit_sel_e         hit_sel;
    logic             cordic_init;
    logic             cordic_step;
    logic [StepW-1:0] cordic_k;
    logic             latch;
    logic             nx_load;
    logic             rot_commit;
    logic             out_load;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic pass;
    logic d_neg;
    logic eyu_zero;
    logic lemn_skip;
  } status_t;

  // Arctangent table in Q.24 half-turns.
  function automatic logic [AngW-1:0] atan_entry(input logic [StepW-1:0] k);
    logic [AngW-1:0] v;
    case (k)
      5'd0:    v = 26'd4194304;
      5'd1:    v = 26'd2476042;
      5'd2:    v = 26'd1308273;
      5'd3:    v = 26'd664100;
      5'd4:    v = 26'd333339;
      5'd5:    v = 26'd166832;
      5'd6:    v = 26'd83436;
      5'd7:    v = 26'd41721;
      5'd8:    v = 26'd20861;
      5'd9:    v = 26'd10430;
      5'd10:   v = 26'd5215;
      5'd11:   v = 26'd2608;
      5'd12:   v = 26'd1304;
      5'd13:   v = 26'd652;
      5'd14:   v = 26'd326;
      5'd15:   v = 26'd163;
      5'd16:   v = 26'd81;
      5'd17:   v = 26'd41;
      5'd18:   v = 26'd20;
      5'd19:   v = 26'd10;
      5'd20:   v = 26'd5;
      5'd21:   v = 26'd3;
      5'd22:   v = 26'd1;
      5'd23:   v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/rspw_cfg.sv
module rspw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rspw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rspw_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          cfg_ready_o,
  output rspw_pkg::cfg_t                cfg_o
);
  import rspw_pkg::*;

  cfg_t cfg_q, cfg_d;

  // The register file takes a beat in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index of a write beat.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegMaxIter: cfg_d.max_iterations  = cfg_data_i[10:0];
        RegSweet:   cfg_d.sweet_iteration = cfg_data_i[9:0];
        RegAlt:     cfg_d.alt_shapes      = cfg_data_i[0];
        RegCutoff:  cfg_d.cutoff          = cfg_data_i[31:0];
        RegRadius:  cfg_d.radius          = cfg_data_i[31:0];
        RegOffX:    cfg_d.offset_x        = cfg_data_i[31:0];
        RegOffY:    cfg_d.offset_y        = cfg_data_i[31:0];
        RegRotStep: cfg_d.rotation_step   = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iterations  <= 11'd25;
      cfg_q.sweet_iteration <= 10'd3;
      cfg_q.alt_shapes      <= 1'b0;
      cfg_q.cutoff          <= 32'sd16777216;
      cfg_q.radius          <= 32'sd6710886;
      cfg_q.offset_x        <= 32'sd10066330;
      cfg_q.offset_y        <= 32'sd0;
      cfg_q.rotation_step   <= 64'd69793772614953508;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/rspw_ctrl.sv
module rspw_ctrl #(
  parameter int unsigned ITERATION_LIMIT = rspw_pkg::IterLimitDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rspw_pkg::cfg_t    cfg_i,
  input  rspw_pkg::status_t status_i,
  output rspw_pkg::cmd_t    cmd_o
);
  import rspw_pkg::*;

  localparam int unsigned CntW = $clog2(ITERATION_LIMIT + 1);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StCut   = 8'b0000_0010,
    StShape = 8'b0000_0100,
    StCirc  = 8'b0000_1000,
    StLemn  = 8'b0001_0000,
    StCord  = 8'b0010_0000,
    StRot   = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] sub_q, sub_d;
  logic [CntW-1:0]  iter_q, iter_d;
  logic [CntW-1:0]  iters;
  logic             rad_neg;
  logic             sweet_match;
  logic             last_iter;

  // Iteration count saturates at the build-time limit.
  always_comb begin
    if (32'(cfg_i.max_iterations) > 32'(ITERATION_LIMIT)) begin
      iters = CntW'(ITERATION_LIMIT);
    end else begin
      iters = CntW'(cfg_i.max_iterations);
    end
  end

  assign rad_neg     = cfg_i.radius[31];
  assign sweet_match = (32'(iter_q) == 32'(cfg_i.sweet_iteration));
  assign last_iter   = ((32'(iter_q) + 32'd1) == 32'(iters));
  assign busy        = (state_q != StIdle);

  // Sequencer: one phase per state, sub_q steps through the phase.
  always_comb begin
    state_d        = state_q;
    sub_d          = sub_q;
    iter_d         = iter_q;
    cmd_o          = '0;
    cmd_o.cordic_k = sub_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          sub_d      = '0;
          iter_d     = '0;
          state_d    = StCut;
        end
      end
      StCut: begin
        sub_d = sub_q + StepW'(1);
        case (sub_q)
          StepW'(0): cmd_o.mul_sel = MulAx2;
          StepW'(1): begin
            cmd_o.mul_sel = MulAy2;
            cmd_o.acc_op  = AccLoad;
          end
          StepW'(2): begin
            cmd_o.mul_sel = MulCo2;
            cmd_o.acc_op  = AccAdd;
          end
          StepW'(3): begin
            cmd_o.mul_sel  = MulRr;
            cmd_o.cut_eval = 1'b1;
          end
          default: begin
            cmd_o.rr_load = 1'b1;
            sub_d         = '0;
            if (status_i.pass || (iters == '0)) begin
              state_d = StOut;
            end else begin
              state_d = StShape;
            end
          end
        endcase
      end
      StShape: begin
        sub_d = '0;
        if (!cfg_i.alt_shapes) begin
          if (rad_neg) begin
            cmd_o.hit_sel = HitSquare;
            state_d       = StRot;
          end else begin
            state_d = StCirc;
          end
        end else if (rad_neg) begin
          if (status_i.eyu_zero) begin
            cmd_o.hit_sel = HitAngleZero;
            state_d       = StRot;
          end else begin
            cmd_o.cordic_init = 1'b1;
            state_d           = StCord;
          end
        end else if (status_i.d_neg) begin
          state_d = StRot;
        end else begin
          state_d = StLemn;
        end
      end
      StCirc: begin
        sub_d = sub_q + StepW'(1);
        case (sub_q)
          StepW'(0): cmd_o.mul_sel = MulDd;
          StepW'(1): begin
            cmd_o.mul_sel = MulEe;
            cmd_o.acc_op  = AccLoad;
          end
          StepW'(2): cmd_o.acc_op = AccAdd;
          default: begin
            cmd_o.hit_sel = HitCircle;
            sub_d         = '0;
            state_d       = StRot;
          end
        endcase
      end
      StLemn: begin
        sub_d = sub_q + StepW'(1);
        case (sub_q)
          StepW'(0): cmd_o.mul_sel = MulDd;
          StepW'(1): begin
            cmd_o.mul_sel = MulEe;
            cmd_o.dd_load = 1'b1;
          end
          StepW'(2): cmd_o.e2_load = 1'b1;
          StepW'(3): begin
            if (status_i.lemn_skip) begin
              sub_d   = '0;
              state_d = StRot;
            end else begin
              cmd_o.mul_sel = MulL00;
            end
          end
          StepW'(4): begin
            cmd_o.mul_sel = MulL01;
            cmd_o.acc_op  = AccLoad;
          end
          StepW'(5): begin
            cmd_o.mul_sel = MulL10;
            cmd_o.acc_op  = AccAdd31;
          end
          StepW'(6): begin
            cmd_o.mul_sel = MulL11;
            cmd_o.acc_op  = AccAdd31;
          end
          StepW'(7): cmd_o.acc_op = AccAdd62;
          default: begin
            cmd_o.hit_sel = HitLemni;
            sub_d         = '0;
            state_d       = StRot;
          end
        endcase
      end
      StCord: begin
        if (32'(sub_q) == CordicSteps) begin
          cmd_o.hit_sel = HitAngle;
          sub_d         = '0;
          state_d       = StRot;
        end else begin
          cmd_o.cordic_step = 1'b1;
          sub_d             = sub_q + StepW'(1);
        end
      end
      StRot: begin
        sub_d = sub_q + StepW'(1);
        case (sub_q)
          StepW'(0): begin
            cmd_o.mul_sel = MulRxC;
            cmd_o.latch   = sweet_match;
          end
          StepW'(1): begin
            cmd_o.mul_sel = MulRyS;
            cmd_o.acc_op  = AccLoad;
          end
          StepW'(2): begin
            cmd_o.mul_sel = MulRxS;
            cmd_o.acc_op  = AccSub;
          end
          StepW'(3): begin
            cmd_o.mul_sel = MulRyC;
            cmd_o.nx_load = 1'b1;
            cmd_o.acc_op  = AccLoad;
          end
          StepW'(4): cmd_o.acc_op = AccAdd;
          default: begin
            cmd_o.rot_commit = 1'b1;
            sub_d            = '0;
            iter_d           = iter_q + CntW'(1);
            if (last_iter) begin
              state_d = StOut;
            end else begin
              state_d = StShape;
            end
          end
        endcase
      end
      StOut: begin
        cmd_o.out_load = 1'b1;
        state_d        = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sub_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      iter_q  <= iter_d;
    end
  end

endmodule

>>> rtl/rspw_dp.sv
module rspw_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rspw_pkg::in_t     point_i,
  input  rspw_pkg::cfg_t    cfg_i,
  input  rspw_pkg::cmd_t    cmd_i,
  output rspw_pkg::status_t status_o,
  output rspw_pkg::out_t    result_o,
  output logic              done_o
);
  import rspw_pkg::*;

  localparam int unsigned RW    = EW + 1;
  localparam int unsigned AngXW = AngW + 1;
  localparam logic signed [AccW-1:0] CoordMax = (AccW'(1) <<< (CoordW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] CoordMin = -CoordMax - AccW'(1);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracBits - 1);

  // Absolute value of a widened difference.
  function automatic logic signed [EW-1:0] abs_e(input logic signed [EW-1:0] v);
    return v[EW-1] ? -v : v;
  endfunction

  // Round half up to Q8.24 and saturate to the coordinate range.
  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = (v + RoundHalf) >>> FracBits;
    if (t > CoordMax) begin
      t = CoordMax;
    end else if (t < CoordMin) begin
      t = CoordMin;
    end
    return t[CoordW-1:0];
  endfunction

  // Negate with saturation of the most negative value.
  function automatic logic signed [CoordW-1:0] neg_sat(input logic signed [CoordW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v == {1'b1, {(CoordW-1){1'b0}}}) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  logic signed [CoordW-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic signed [CoordW-1:0] rx_q, ry_q, rx_d, ry_d;
  logic signed [CoordW-1:0] lx_q, ly_q, lx_d, ly_d;
  logic signed [CoordW-1:0] nx_q, nx_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic [63:0]              rr_q, rr_d, dd_q, dd_d, e2_q, e2_d;
  logic signed [CordW-1:0]  cx_q, cy_q, cx_d, cy_d;
  logic signed [AngW-1:0]   cz_q, cz_d;
  out_t                     res_q, res_d;
  logic                     parity_q, parity_d, pass_q, pass_d, done_q, done_d;

  logic signed [EW-1:0]     d, ey, eyu, ad, ae, aeu, apx, apy, m_sq, m_cut;
  logic signed [MulW-1:0]   ma, mb;
  logic signed [AccW-1:0]   pext;
  logic [63:0]              diff;
  logic [HalfW-1:0]         a0, a1, b0, b1;
  logic signed [CoordW-1:0] rot_c, rot_s;
  logic signed [CordW-1:0]  csx, csy;
  logic signed [AngXW-1:0]  ang_res, ang_zero;
  logic signed [RW-1:0]     nrad, ncut;
  logic                     hit, cut_sq, cut_circ;

  // Offsets from the shape centre and their magnitudes.
  assign d     = EW'(rx_q) - EW'(cfg_i.offset_x);
  assign ey    = EW'(ry_q) - EW'(cfg_i.offset_y);
  assign eyu   = EW'(py_q) - EW'(cfg_i.offset_y);
  assign ad    = abs_e(d);
  assign ae    = abs_e(ey);
  assign aeu   = abs_e(eyu);
  assign apx   = abs_e(EW'(px_q));
  assign apy   = abs_e(EW'(py_q));
  assign m_sq  = (ad > aeu) ? ad : aeu;
  assign m_cut = (apx > apy) ? apx : apy;
  assign nrad  = -(RW'(cfg_i.radius));
  assign ncut  = -(RW'(cfg_i.cutoff));

  assign rot_c = cfg_i.rotation_step[63:32];
  assign rot_s = cfg_i.rotation_step[31:0];

  // Halves of the lemniscate product operands.
  assign diff = rr_q - dd_q;
  assign a0   = dd_q[HalfW-1:0];
  assign a1   = dd_q[2*HalfW-1:HalfW];
  assign b0   = diff[HalfW-1:0];
  assign b1   = diff[2*HalfW-1:HalfW];

  // Operand select for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      MulAx2: begin ma = apx; mb = apx; end
      MulAy2: begin ma = apy; mb = apy; end
      MulCo2: begin ma = MulW'(cfg_i.cutoff); mb = MulW'(cfg_i.cutoff); end
      MulRr:  begin ma = MulW'(cfg_i.radius); mb = MulW'(cfg_i.radius); end
      MulDd:  begin ma = ad; mb = ad; end
      MulEe:  begin ma = ae; mb = ae; end
      MulL00: begin ma = $signed(MulW'(a0)); mb = $signed(MulW'(b0)); end
      MulL01: begin ma = $signed(MulW'(a0)); mb = $signed(MulW'(b1)); end
      MulL10: begin ma = $signed(MulW'(a1)); mb = $signed(MulW'(b0)); end
      MulL11: begin ma = $signed(MulW'(a1)); mb = $signed(MulW'(b1)); end
      MulRxC: begin ma = MulW'(rx_q); mb = MulW'(rot_c); end
      MulRyS: begin ma = MulW'(ry_q); mb = MulW'(rot_s); end
      MulRxS: begin ma = MulW'(rx_q); mb = MulW'(rot_s); end
      MulRyC: begin ma = MulW'(ry_q); mb = MulW'(rot_c); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_d = ma * mb;
  assign pext   = AccW'(prod_q);

  // Accumulator over the registered products.
  always_comb begin
    case (cmd_i.acc_op)
      AccLoad:  acc_d = pext;
      AccAdd:   acc_d = acc_q + pext;
      AccSub:   acc_d = acc_q - pext;
      AccAdd31: acc_d = acc_q + (pext <<< HalfW);
      AccAdd62: acc_d = acc_q + (pext <<< (2 * HalfW));
      default:  acc_d = acc_q;
    endcase
  end

  // Angle of the offset vector in half-turns, folded for a negative x.
  assign csx      = cx_q >>> cmd_i.cordic_k;
  assign csy      = cy_q >>> cmd_i.cordic_k;
  assign ang_res  = d[EW-1] ? (AngXW'(HalfTurn) - AngXW'(cz_q)) : AngXW'(cz_q);
  assign ang_zero = d[EW-1] ? AngXW'(HalfTurn) : '0;

  // Shape hit for the selected test.
  always_comb begin
    case (cmd_i.hit_sel)
      HitSquare:    hit = (RW'(m_sq) <= nrad);
      HitCircle:    hit = ($unsigned(acc_q) <= AccW'(rr_q));
      HitLemni:     hit = ((AccW'(e2_q) << (2 * FracBits)) <= $unsigned(acc_q));
      HitAngle:     hit = (RW'(ang_res) <= nrad);
      HitAngleZero: hit = (RW'(ang_zero) <= nrad);
      default:      hit = 1'b0;
    endcase
  end

  // Cutoff region test.
  assign cut_sq   = (RW'(m_cut) > ncut);
  assign cut_circ = (acc_q > pext);

  // Next state of the datapath registers.
  always_comb begin
    px_d     = px_q;
    py_d     = py_q;
    pz_d     = pz_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    lx_d     = lx_q;
    ly_d     = ly_q;
    nx_d     = nx_q;
    rr_d     = rr_q;
    dd_d     = dd_q;
    e2_d     = e2_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    res_d    = res_q;
    parity_d = parity_q ^ hit;
    pass_d   = pass_q;
    done_d   = cmd_i.out_load;

    if (cmd_i.load) begin
      px_d     = point_i.point_x;
      py_d     = point_i.point_y;
      pz_d     = point_i.point_z;
      rx_d     = point_i.point_x;
      ry_d     = point_i.point_y;
      lx_d     = point_i.point_x;
      ly_d     = point_i.point_y;
      parity_d = !cfg_i.offset_x[31] && (cfg_i.offset_x != '0);
      pass_d   = 1'b0;
    end
    if (cmd_i.cut_eval) begin
      pass_d = cfg_i.cutoff[31] ? cut_sq : cut_circ;
    end
    if (cmd_i.rr_load) begin
      rr_d = prod_q[63:0];
    end
    if (cmd_i.dd_load) begin
      dd_d = prod_q[63:0];
    end
    if (cmd_i.e2_load) begin
      e2_d = prod_q[63:0];
    end
    if (cmd_i.cordic_init) begin
      cx_d = CordW'(ad);
      cy_d = CordW'(aeu);
      cz_d = '0;
    end
    if (cmd_i.cordic_step) begin
      if (!cy_q[CordW-1]) begin
        cx_d = cx_q + csy;
        cy_d = cy_q - csx;
        cz_d = cz_q + $signed(atan_entry(cmd_i.cordic_k));
      end else begin
        cx_d = cx_q - csy;
        cy_d = cy_q + csx;
        cz_d = cz_q - $signed(atan_entry(cmd_i.cordic_k));
      end
    end
    if (cmd_i.latch) begin
      lx_d = rx_q;
      ly_d = ry_q;
    end
    if (cmd_i.nx_load) begin
      nx_d = round_sat(acc_q);
    end
    if (cmd_i.rot_commit) begin
      rx_d = nx_q;
      ry_d = round_sat(acc_q);
    end
    if (cmd_i.out_load) begin
      res_d.out_z = pz_q;
      if (pass_q || !parity_q) begin
        res_d.out_x              = px_q;
        res_d.out_y              = py_q;
        res_d.used_latched_point = 1'b0;
      end else begin
        res_d.used_latched_point = 1'b1;
        if (cfg_i.sweet_iteration == '0) begin
          res_d.out_x = (cfg_i.offset_y != '0) ? neg_sat(lx_q) : lx_q;
          res_d.out_y = neg_sat(ly_q);
        end else begin
          res_d.out_x = lx_q;
          res_d.out_y = ly_q;
        end
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      pass_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      parity_q <= parity_d;
      pass_q   <= pass_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    lx_q   <= lx_d;
    ly_q   <= ly_d;
    nx_q   <= nx_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rr_q   <= rr_d;
    dd_q   <= dd_d;
    e2_q   <= e2_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    res_q  <= res_d;
  end

  assign status_o.pass      = pass_q;
  assign status_o.d_neg     = d[EW-1];
  assign status_o.eyu_zero  = (eyu == '0);
  assign status_o.lemn_skip = (rr_q < dd_q);
  assign result_o           = res_q;
  assign done_o             = done_q;

endmodule

>>> rtl/rotated_shape_parity_warp.sv
// A point is first tested against the cutoff; one outside it, or any with no iterations set,
// goes straight to the output, else each iteration runs one shape test (square, zero angle,
// circle, lemniscate or angle by a 24-step CORDIC) and then a rotation of the working point.
// One point at a time: busy drops in the cycle done_o is high, so a new point is taken
// only once the last one is done. One shared 33x33 multiplier serves every step in turn.
// A result is shown for one cycle on done_o; the receiver cannot stall it.
// Reset (rst_ni, async, active low) idles the sequencer and loads the register defaults.
module rotated_shape_parity_warp #(
  parameter int unsigned ITERATION_LIMIT = rspw_pkg::IterLimitDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rspw_pkg::in_t                 point_i,
  output logic                          done_o,
  output rspw_pkg::out_t                result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rspw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rspw_pkg::CfgDataW-1:0] cfg_data_i
);
  import rspw_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration register file.
  rspw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // Sequencer.
  rspw_ctrl #(
    .ITERATION_LIMIT (ITERATION_LIMIT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cfg_i    (cfg),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Arithmetic datapath.
  rspw_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_i),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rspw_pkg::*;

  localparam logic signed [127:0] CoordMax = 128'sh7fff_ffff;
  localparam logic signed [127:0] CoordMin = -CoordMax - 1;
  localparam logic signed [127:0] HalfTurnQ = 128'sd16777216;

  // Arctangent steps in Q.24 half-turns for the angle test.
  localparam int AtanQ24 [24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         point_i;
  logic        done_o;
  out_t        result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  rotated_shape_parity_warp dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .point_i(point_i),
    .done_o(done_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Register copy kept in step with every write, and results still owed.
  cfg_t regs_shadow;
  out_t pending_warps[$];
  int   fail_count;

  typedef struct {
    in_t  pt;
    bit   known;
    out_t res;
  } point_row_t;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic signed [127:0] clamp_coord(logic signed [127:0] v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic logic signed [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Half-turn angle of (a, b) by the fixed CORDIC, folded to 0..1.
  function automatic logic signed [127:0] half_turns(logic signed [127:0] a,
                                                     logic signed [127:0] b);
    logic signed [127:0] x, y, acc, nx;
    acc = 0;
    b = mag(b);
    if (b == 0) return (a < 0) ? HalfTurnQ : 0;
    x = mag(a);
    y = b;
    for (int k = 0; k < 24; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k);
        y = y - (x >>> k);
        acc = acc + 128'(AtanQ24[k]);
      end else begin
        nx = x - (y >>> k);
        y = y + (x >>> k);
        acc = acc - 128'(AtanQ24[k]);
      end
      x = nx;
    end
    return (a < 0) ? HalfTurnQ - acc : acc;
  endfunction

  // Shape test about the offset; square and angle use the unrotated y.
  function automatic bit shape_hit(logic signed [127:0] rx, logic signed [127:0] ry,
                                   logic signed [127:0] py);
    logic signed [127:0] rad, d, ey, eyu, m;
    logic [63:0] ad, ae, s1, s, rr, dd, e2;
    logic [127:0] prod, lhs;
    rad = 128'(regs_shadow.radius);
    d = rx - 128'(regs_shadow.offset_x);
    ey = ry - 128'(regs_shadow.offset_y);
    eyu = py - 128'(regs_shadow.offset_y);
    if (!regs_shadow.alt_shapes) begin
      if (rad < 0) begin
        m = (mag(d) > mag(eyu)) ? mag(d) : mag(eyu);
        return m <= -rad;
      end
      // Squares wrap at 64 bits, as the sum check does.
      ad = 64'(mag(d));
      ae = 64'(mag(ey));
      s1 = ad * ad;
      s = s1 + ae * ae;
      rr = rad[63:0] * rad[63:0];
      if (s < s1) return 1'b0;
      return s <= rr;
    end
    if (rad < 0) return half_turns(d, eyu) <= -rad;
    if (d < 0) return 1'b0;
    dd = d[63:0] * d[63:0];
    rr = rad[63:0] * rad[63:0];
    ae = 64'(mag(ey));
    e2 = ae * ae;
    if (rr < dd) return 1'b0;
    prod = {64'd0, dd} * {64'd0, rr - dd};
    lhs = {64'd0, e2} << 48;
    return lhs <= prod;
  endfunction

  // Expected output of one point under the current register copy.
  function automatic out_t predict_warp(in_t p);
    logic signed [127:0] x, y, co, c, s, rx, ry, lx, ly, nx, ny, ox, oy;
    bit passed, parity;
    int iters;
    out_t r;
    x = 128'(p.point_x);
    y = 128'(p.point_y);
    co = 128'(regs_shadow.cutoff);
    c = 128'($signed(regs_shadow.rotation_step[63:32]));
    s = 128'($signed(regs_shadow.rotation_step[31:0]));
    if (co >= 0) passed = (x * x + y * y) > co * co;
    else passed = ((mag(x) > mag(y)) ? mag(x) : mag(y)) > -co;
    parity = 1'b0;
    ox = x;
    oy = y;
    if (!passed) begin
      iters = (regs_shadow.max_iterations > 1024) ? 1024 : int'(regs_shadow.max_iterations);
      parity = (regs_shadow.offset_x > 0);
      rx = x; ry = y; lx = x; ly = y;
      for (int i = 0; i < iters; i++) begin
        if (shape_hit(rx, ry, y)) parity = !parity;
        if (i == int'(regs_shadow.sweet_iteration)) begin
          lx = rx;
          ly = ry;
        end
        nx = clamp_coord((rx * c - ry * s + 128'sd8388608) >>> 24);
        ny = clamp_coord((rx * s + ry * c + 128'sd8388608) >>> 24);
        rx = nx;
        ry = ny;
      end
      if (parity) begin
        if (regs_shadow.sweet_iteration == 0) begin
          ox = (regs_shadow.offset_y != 0) ? clamp_coord(-lx) : lx;
          oy = clamp_coord(-ly);
        end else begin
          ox = lx;
          oy = ly;
        end
      end
    end
    r.out_x = ox[31:0];
    r.out_y = oy[31:0];
    r.out_z = p.point_z;
    r.used_latched_point = !passed && parity;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMaxIter: regs_shadow.max_iterations = value[10:0];
      RegSweet:   regs_shadow.sweet_iteration = value[9:0];
      RegAlt:     regs_shadow.alt_shapes = value[0];
      RegCutoff:  regs_shadow.cutoff = value[31:0];
      RegRadius:  regs_shadow.radius = value[31:0];
      RegOffX:    regs_shadow.offset_x = value[31:0];
      RegOffY:    regs_shadow.offset_y = value[31:0];
      RegRotStep: regs_shadow.rotation_step = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender holds off until every owed result is back and the block is idle.
  task automatic drain_warps();
    while (pending_warps.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
  endtask

  // One point beat; start stays high across back-to-back beats.
  task automatic send_point(in_t p, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy);
    pending_warps.push_back(predict_warp(p));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic load_regs(logic [10:0] it, logic [9:0] sw, bit alt, int cut, int rad,
                           int offx, int offy, logic [63:0] rot);
    drain_warps();
    write_reg(RegMaxIter, 64'(it));
    write_reg(RegSweet, 64'(sw));
    write_reg(RegAlt, 64'(alt));
    write_reg(RegCutoff, 64'(signed'(cut)));
    write_reg(RegRadius, 64'(signed'(rad)));
    write_reg(RegOffX, 64'(signed'(offx)));
    write_reg(RegOffY, 64'(signed'(offy)));
    write_reg(RegRotStep, rot);
  endtask

  function automatic int near(int centre, int span);
    return centre + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly points near the shape or inside the cutoff, some anywhere.
  function automatic in_t rand_point();
    in_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.point_z = $urandom;
    if (mode == 0) begin
      p.point_x = $urandom;
      p.point_y = $urandom;
    end else if (mode <= 3) begin
      p.point_x = near(regs_shadow.offset_x, 1 << 23);
      p.point_y = near(regs_shadow.offset_y, 1 << 23);
    end else begin
      p.point_x = near(0, 1 << $urandom_range(20, 25));
      p.point_y = near(0, 1 << $urandom_range(20, 25));
    end
    return p;
  endfunction

  task automatic random_points(int count);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      send_point(rand_point(), steady ? 0 : $urandom_range(0, 13));
    end
    stop_sending();
  endtask

  function automatic logic [63:0] rand_rotation();
    real t;
    int cq, sq;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    t = $urandom_range(0, 62831) / 10000.0;
    cq = $rtoi($cos(t) * 16777216.0);
    sq = $rtoi($sin(t) * 16777216.0);
    return {cq, sq};
  endfunction

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_warps.size() == 0) begin
        $error("result with no point outstanding");
        fail_count++;
      end else begin
        out_t w;
        w = pending_warps.pop_front();
        if (result_o.out_x !== w.out_x) begin
          $error("out_x expected %h actual %h", w.out_x, result_o.out_x);
          fail_count++;
        end
        if (result_o.out_y !== w.out_y) begin
          $error("out_y expected %h actual %h", w.out_y, result_o.out_y);
          fail_count++;
        end
        if (result_o.out_z !== w.out_z) begin
          $error("out_z expected %h actual %h", w.out_z, result_o.out_z);
          fail_count++;
        end
        if (result_o.used_latched_point !== w.used_latched_point) begin
          $error("used_latched_point expected %b actual %b", w.used_latched_point,
                 result_o.used_latched_point);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("rotated_shape_parity_warp test failed");
    $finish;
  end

  initial begin
    point_row_t rows[$];
    int alt, cut, rad;
    logic [10:0] it;

    fail_count = 0;
    start = 1'b0;
    point_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegMaxIter;
    cfg_data_i = '0;
    regs_shadow = '{max_iterations: 11'd25, sweet_iteration: 10'd3, alt_shapes: 1'b0,
                    cutoff: 32'sd16777216, radius: 32'sd6710886,
                    offset_x: 32'sd10066330, offset_y: 32'sd0,
                    rotation_step: 64'd69793772614953508};
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed points under the reset settings; extremes lie outside the cutoff.
    rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1,
                     '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0}});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000}, 1,
                     '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0}});
    rows.push_back('{'{32'h01000001, 32'h0, 32'hffffffff}, 1,
                     '{32'h01000001, 32'h0, 32'hffffffff, 1'b0}});
    rows.push_back('{'{32'h0, 32'h0, 32'h0}, 0, '0});
    rows.push_back('{'{32'h01000000, 32'h0, 32'h5}, 0, '0});
    rows.push_back('{'{32'h0, 32'hff000000, 32'h12345678}, 0, '0});
    rows.push_back('{'{32'h00999999, 32'h0, 32'h7}, 0, '0});
    rows.push_back('{'{32'h00800000, 32'h00400000, 32'h9}, 0, '0});
    rows.push_back('{'{32'hff800000, 32'h00200000, 32'ha}, 0, '0});
    rows.push_back('{'{32'h00a00000, 32'hfff00000, 32'hb}, 0, '0});
    rows.push_back('{'{32'h00000001, 32'hffffffff, 32'hc}, 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].pt, $urandom_range(0, 13));
      if (rows[i].known && predict_warp(rows[i].pt) !== rows[i].res) begin
        $error("directed row %0d disagrees with its typed result", i);
        fail_count++;
      end
    end
    stop_sending();

    // Zero iterations: parity stays at its start value, the input is latched.
    load_regs(11'd0, 10'd3, 0, 32'sd16777216, 32'sd6710886, 32'sd10066330, 0,
              64'd69793772614953508);
    send_point('{32'h00100000, 32'h00200000, 32'h1}, 0);
    send_point('{32'hfff00000, 32'h00000000, 32'h2}, 0);
    stop_sending();
    // Iteration count above the limit saturates; sweet index 1023 falls on the last iteration.
    load_regs(11'd2047, 10'd1023, 0, 32'sd16777216, 32'sd6710886, 32'sd10066330, 0,
              64'd69793772614953508);
    send_point('{32'h00800000, 32'h00100000, 32'h3}, 0);
    send_point('{32'h00100000, 32'hffe00000, 32'h4}, 3);
    stop_sending();
    // Sweet iteration zero with and without a y offset, most negative x.
    load_regs(11'd1, 10'd0, 0, 32'h80000000, 32'h80000000, 32'sd1, 32'sd5, 64'd0);
    send_point('{32'h80000000, 32'h80000000, 32'h5}, 0);
    send_point('{32'h00000000, 32'h00000000, 32'h6}, 0);
    stop_sending();
    load_regs(11'd3, 10'd0, 0, 32'sd33554432, 32'sd8388608, 32'sd1, 0,
              64'hffffffffffffffff);
    send_point('{32'h00000001, 32'h00000001, 32'h7}, 0);
    send_point('{32'h00400000, 32'hffc00000, 32'h8}, 2);
    stop_sending();
    // Angle shape, including the zero vector on both sides of the offset.
    load_regs(11'd4, 10'd1, 1, 32'sd33554432, -32'sd8388608, 0, 32'sd4194304,
              64'h00b504f300b504f3);
    send_point('{32'hff000000, 32'h00400000, 32'h9}, 0);
    send_point('{32'h00800000, 32'h00400000, 32'ha}, 0);
    send_point('{32'h00200000, 32'hff800000, 32'hb}, 0);
    stop_sending();
    // Lemniscate with the largest radius and a circular cutoff at its widest.
    load_regs(11'd6, 10'd2, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              rand_rotation());
    random_points(4);
    // One angle point at the full iteration count.
    load_regs(11'd1024, 10'd700, 1, 32'sd16777216, -32'sd16777216, 0, 0,
              64'h00fb14be0031f170);
    send_point('{32'h00400000, 32'h00100000, 32'hc}, 0);
    stop_sending();

    // Random register settings, each followed by a batch of points.
    for (int ph = 0; ph < 24; ph++) begin
      alt = $urandom_range(0, 1);
      it = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 3)) :
                                         11'($urandom_range(1, alt ? 20 : 40));
      case ($urandom_range(0, 9))
        0:       cut = $urandom;
        1, 2:    cut = -$urandom_range(1 << 23, 1 << 26);
        default: cut = $urandom_range(1 << 23, 1 << 26);
      endcase
      rad = $urandom_range(0, 1 << 25);
      if ($urandom_range(0, 2) == 0) rad = -(alt ? $urandom_range(0, 1 << 24) : rad);
      load_regs(it, 10'($urandom_range(0, it + 1)), 1'(alt), cut, rad, near(0, 1 << 24),
                ($urandom_range(0, 2) == 0) ? 0 : near(0, 1 << 24), rand_rotation());
      random_points(35);
    end

    drain_warps();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rotated_shape_parity_warp test passed");
    end else begin
      $display("rotated_shape_parity_warp test failed");
    end
    $finish;
  end

endmodule
